/* rtl/peak_window_filter_gradient_core_defines.svh */
// ----------------------------------------------------------------------------
// peak_window_filter_gradient_core_defines.svh
// Assertion macros for the peak window filter gradient core.
// ----------------------------------------------------------------------------
`ifndef PEAK_WINDOW_FILTER_GRADIENT_CORE_DEFINES_SVH
`define PEAK_WINDOW_FILTER_GRADIENT_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define PWFG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pwfg: implication check failed");

// condition must never hold
`define PWFG_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("pwfg: forbidden condition seen");

`else

`define PWFG_ASSERT_IMP(lbl, ante, cons)
`define PWFG_ASSERT_NEVER(lbl, cond)

`endif

`endif

/* rtl/pwfg_pkg.sv */
// ----------------------------------------------------------------------------
// pwfg_pkg
// Shared field widths, codes and types of the filter gradient core.
// ----------------------------------------------------------------------------
package pwfg_pkg;

  localparam int FUNC_W     = 2;
  localparam int ELEM_W     = 6;
  localparam int ROWCOL_W   = 4;
  localparam int SAMPLE_W   = 16;
  localparam int CHAN_W     = 6;
  localparam int PEAK_W     = 8;
  localparam int WEIGHT_W   = 16;
  localparam int PROD_W     = SAMPLE_W + WEIGHT_W;
  localparam int ACC_W      = 40;
  localparam int TAP_IDX_W  = 5;
  localparam int PAD_W      = 3;
  localparam int COORD_W    = 11;   // signed window coordinate
  localparam int Q_W        = PEAK_W + 1;
  localparam int RECIP_SHIFT = 16;
  localparam int QPROD_W    = PEAK_W + RECIP_SHIFT + 1;

  localparam logic [PAD_W-1:0] PAD_RESET = 3'd2;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [FUNC_W-1:0] {
    FN_LOAD  = 2'd0,
    FN_ACC   = 2'd1,
    FN_DRAIN = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC_DIV,
    ST_ACC_COL,
    ST_ACC_RUN,
    ST_ACC_FLUSH,
    ST_DRN_RD,
    ST_DRN_OUT
  } state_t;

  // per-tap control riding along the update pipeline
  typedef struct packed {
    logic vld;
    logic inb;      // tap inside plane bounds
    logic acc_vld;  // channel holds live data, else reads as zero
  } mac_ctl_t;

  typedef struct packed {
    logic a_vld;
    logic b_vld;
  } mac_stat_t;

endpackage

/* rtl/pwfg_in_if.sv */
// ----------------------------------------------------------------------------
// pwfg_in_if
// Request channel into the filter gradient core.
// ----------------------------------------------------------------------------
interface pwfg_in_if import pwfg_pkg::*; ();

  logic                       valid;
  logic                       ready;
  logic [FUNC_W-1:0]          func;
  logic [ELEM_W-1:0]          element;
  logic [ROWCOL_W-1:0]        sample_row;
  logic [ROWCOL_W-1:0]        sample_col;
  logic signed [SAMPLE_W-1:0] pixel_value;
  logic [CHAN_W-1:0]          out_channel;
  logic [PEAK_W-1:0]          peak_index;
  logic signed [WEIGHT_W-1:0] weight;

  modport source (
    output valid, func, element, sample_row, sample_col, pixel_value,
           out_channel, peak_index, weight,
    input  ready
  );

  modport sink (
    input  valid, func, element, sample_row, sample_col, pixel_value,
           out_channel, peak_index, weight,
    output ready
  );

endinterface

/* rtl/pwfg_out_if.sv */
// ----------------------------------------------------------------------------
// pwfg_out_if
// Result channel out of the filter gradient core.
// ----------------------------------------------------------------------------
interface pwfg_out_if import pwfg_pkg::*; ();

  logic                    valid;
  logic                    ready;
  logic signed [ACC_W-1:0] filter_value;
  logic [TAP_IDX_W-1:0]    tap_index;
  logic [CHAN_W-1:0]       drained_channel;
  logic                    last;

  modport source (
    output valid, filter_value, tap_index, drained_channel, last,
    input  ready
  );

  modport sink (
    input  valid, filter_value, tap_index, drained_channel, last,
    output ready
  );

endinterface

/* rtl/pwfg_ram.sv */
// ----------------------------------------------------------------------------
// pwfg_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pwfg_ram #(
  parameter  int WIDTH = 16,
  parameter  int DEPTH = 1024,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/pwfg_mac.sv */
// ----------------------------------------------------------------------------
// pwfg_mac
// Tap update pipeline: multiply, scale, saturating add, write back.
// ----------------------------------------------------------------------------
module pwfg_mac import pwfg_pkg::*; #(
  parameter int AW    = 11,
  parameter int SHIFT = 6
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mac_ctl_t                   in_ctl,   // issue cycle
  input  logic [AW-1:0]              in_addr,  // issue cycle
  input  logic signed [WEIGHT_W-1:0] weight,   // held for the whole item
  input  logic [SAMPLE_W-1:0]        sample,   // RAM data, cycle after issue
  input  logic [ACC_W-1:0]           acc_rd,   // RAM data, cycle after issue
  output logic                       wr_en,
  output logic [AW-1:0]              wr_addr,
  output logic [ACC_W-1:0]           wr_data,
  output mac_stat_t                  stat
);

  // stage a: lines up with the RAM read latency
  mac_ctl_t                 a_ctl_r;
  logic [AW-1:0]            a_addr_r;
  // stage b: product and old accumulator
  mac_ctl_t                 b_ctl_r;
  logic [AW-1:0]            b_addr_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;

  logic signed [PROD_W-1:0] term;
  logic signed [ACC_W:0]    sum;
  logic signed [ACC_W-1:0]  sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_ctl_r <= '0;
      b_ctl_r <= '0;
    end else begin
      a_ctl_r <= in_ctl;
      b_ctl_r <= a_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    a_addr_r <= in_addr;
    b_addr_r <= a_addr_r;
    prod_r   <= $signed(sample) * weight;
    acc_r    <= a_ctl_r.acc_vld ? $signed(acc_rd) : '0;
  end

  // arithmetic shift rounds toward minus infinity
  always_comb begin
    term = prod_r >>> SHIFT;
    sum  = $signed((ACC_W+1)'(term)) + $signed((ACC_W+1)'(acc_r));
    if (sum[ACC_W] != sum[ACC_W-1]) begin
      sat = sum[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      sat = sum[ACC_W-1:0];
    end
  end

  // out-of-plane taps write back the old value (zero for a fresh channel)
  assign wr_en   = b_ctl_r.vld;
  assign wr_addr = b_addr_r;
  assign wr_data = b_ctl_r.inb ? sat : acc_r;

  assign stat.a_vld = a_ctl_r.vld;
  assign stat.b_vld = b_ctl_r.vld;

endmodule

/* rtl/peak_window_filter_gradient_core.sv */
// ----------------------------------------------------------------------------
// peak_window_filter_gradient_core
// Windowed filter gradient accumulator over a sample store and a tap store.
//
// Requests arrive on in_if (valid/ready). A load request writes one sample
// into the plane RAM. An accumulate request walks the FILTER_ROWS x
// FILTER_COLS window one tap per cycle through a shared multiply-accumulate
// that reads and writes the tap RAM. A drain request reads the channel's
// taps one by one and sends one result per tap on out_if; a stall on out_if
// holds the drain at the current tap. Results sit in an output register, so
// a new request is taken while the last result of a drain still waits.
// cfg_we/cfg_wdata set pad_offset and are to be written only while idle;
// the block itself does not enforce this.
// Reset (rst_n low, synchronous) sets pad_offset to 2 and marks every
// channel empty through one flag per channel: an empty channel reads as
// zero, so there is no clearing pass. Sample RAM content is undefined.
// ----------------------------------------------------------------------------
`include "peak_window_filter_gradient_core_defines.svh"

module peak_window_filter_gradient_core import pwfg_pkg::*; #(
  parameter int BATCH        = 64,
  parameter int PLANE_ROWS   = 12,
  parameter int PLANE_COLS   = 12,
  parameter int OUT_CHANNELS = 64,
  parameter int FILTER_ROWS  = 5,
  parameter int FILTER_COLS  = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  pwfg_in_if.sink          in_if,
  pwfg_out_if.source       out_if,
  input  logic             cfg_we,
  input  logic [PAD_W-1:0] cfg_wdata
);

  localparam int PLANE_SIZE  = PLANE_ROWS * PLANE_COLS;
  localparam int PLANE_DEPTH = BATCH * PLANE_SIZE;
  localparam int PA_W        = (PLANE_DEPTH > 1) ? $clog2(PLANE_DEPTH) : 1;
  localparam int TAPS        = FILTER_ROWS * FILTER_COLS;
  localparam int TAP_DEPTH   = OUT_CHANNELS * TAPS;
  localparam int TA_W        = (TAP_DEPTH > 1) ? $clog2(TAP_DEPTH) : 1;
  localparam int T_W         = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int R_W         = (FILTER_ROWS > 1) ? $clog2(FILTER_ROWS) : 1;
  localparam int C_W         = (FILTER_COLS > 1) ? $clog2(FILTER_COLS) : 1;
  localparam int CH_W        = (OUT_CHANNELS > 1) ? $clog2(OUT_CHANNELS) : 1;
  localparam int CL_W        = (PLANE_COLS > 1) ? $clog2(PLANE_COLS) : 1;
  localparam int SHIFT       = $clog2(BATCH + 1) - 1;   // floor(log2(BATCH))
  // peak / PLANE_COLS by reciprocal; exact for peak < 256, cols <= 64
  localparam int RECIP = ((1 << RECIP_SHIFT) + PLANE_COLS - 1) / PLANE_COLS;

  // --------------------------------------------------------------------------
  // Control state
  // --------------------------------------------------------------------------
  state_t             state_r, state_nxt;
  logic [R_W-1:0]     r_cnt_r, r_cnt_nxt;
  logic [C_W-1:0]     c_cnt_r, c_cnt_nxt;
  logic [T_W-1:0]     t_cnt_r, t_cnt_nxt;
  logic [PAD_W-1:0]   pad_r;
  logic [OUT_CHANNELS-1:0] ch_vld_r;    // channel has been written since clear
  logic               out_valid_r, out_valid_nxt;

  // request payload and per-item setup
  logic [ELEM_W-1:0]          element_r;
  logic [CHAN_W-1:0]          chan_r;
  logic [PEAK_W-1:0]          peak_r;
  logic signed [WEIGHT_W-1:0] weight_r;
  logic                       acc_vld_r;
  logic [TA_W-1:0]            tap_base_r;
  logic [PA_W-1:0]            elem_base_r;
  logic [Q_W-1:0]             q_r;      // peak row
  logic [CL_W-1:0]            col_r;    // peak column

  // result register
  logic signed [ACC_W-1:0]    out_value_r;
  logic [TAP_IDX_W-1:0]       out_tap_r;
  logic [CHAN_W-1:0]          out_chan_r;
  logic                       out_last_r;

  // --------------------------------------------------------------------------
  // Combinational signals
  // --------------------------------------------------------------------------
  logic                  in_accept;
  logic                  load_ok, acc_ok, drain_ok;
  logic [CH_W-1:0]       in_chan_idx, chan_idx;
  logic                  out_free, out_load;
  logic                  vld_set, vld_clr;
  logic                  t_last;
  logic [QPROD_W-1:0]    qprod;
  logic [Q_W-1:0]        col_diff;
  logic signed [COORD_W-1:0] ir_s, ic_s;
  logic                  inb;

  logic                  plane_we, plane_re;
  logic [PA_W-1:0]       plane_waddr, plane_raddr;
  logic [SAMPLE_W-1:0]   plane_rdata;

  logic                  tap_re;
  logic [TA_W-1:0]       tap_raddr;
  logic [ACC_W-1:0]      tap_rdata;
  logic                  tap_we;
  logic [TA_W-1:0]       tap_waddr;
  logic [ACC_W-1:0]      tap_wdata;

  mac_ctl_t              issue_ctl;
  mac_stat_t             mac_stat;

  // requests are taken only between items
  assign in_if.ready = (state_r == ST_IDLE);
  assign in_accept   = in_if.valid && in_if.ready;

  // range checks on the incoming request
  assign load_ok  = ((ELEM_W+3)'(in_if.element) < (ELEM_W+3)'(BATCH)) &&
                    ((ROWCOL_W+3)'(in_if.sample_row) < (ROWCOL_W+3)'(PLANE_ROWS)) &&
                    ((ROWCOL_W+3)'(in_if.sample_col) < (ROWCOL_W+3)'(PLANE_COLS));
  assign drain_ok = (CHAN_W+3)'(in_if.out_channel) < (CHAN_W+3)'(OUT_CHANNELS);
  assign acc_ok   = drain_ok && ((ELEM_W+3)'(in_if.element) < (ELEM_W+3)'(BATCH));

  assign in_chan_idx = CH_W'(in_if.out_channel);
  assign chan_idx    = CH_W'(chan_r);

  assign out_free = !out_valid_r || out_if.ready;
  assign t_last   = (t_cnt_r == T_W'(TAPS - 1));

  // peak row by reciprocal multiply, then column by multiply-subtract
  assign qprod    = QPROD_W'(peak_r) * QPROD_W'(RECIP);
  assign col_diff = Q_W'(peak_r) - Q_W'(q_r * Q_W'(PLANE_COLS));

  // window coordinate of the current tap
  assign ir_s = $signed(COORD_W'(q_r)) + $signed(COORD_W'(r_cnt_r))
              - $signed(COORD_W'(pad_r));
  assign ic_s = $signed(COORD_W'(col_r)) + $signed(COORD_W'(c_cnt_r))
              - $signed(COORD_W'(pad_r));
  assign inb  = !ir_s[COORD_W-1] && !ic_s[COORD_W-1] &&
                ($unsigned(ir_s) < COORD_W'(PLANE_ROWS)) &&
                ($unsigned(ic_s) < COORD_W'(PLANE_COLS));

  assign plane_waddr = PA_W'(in_if.element) * PA_W'(PLANE_SIZE)
                     + PA_W'(in_if.sample_row) * PA_W'(PLANE_COLS)
                     + PA_W'(in_if.sample_col);
  assign plane_raddr = elem_base_r + PA_W'(ir_s) * PA_W'(PLANE_COLS) + PA_W'(ic_s);
  assign tap_raddr   = tap_base_r + TA_W'(t_cnt_r);

  // --------------------------------------------------------------------------
  // Sequencer: next state and strobes
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt   = state_r;
    r_cnt_nxt   = r_cnt_r;
    c_cnt_nxt   = c_cnt_r;
    t_cnt_nxt   = t_cnt_r;
    plane_we    = 1'b0;
    plane_re    = 1'b0;
    tap_re      = 1'b0;
    issue_ctl   = '0;
    vld_set     = 1'b0;
    vld_clr     = 1'b0;
    out_load    = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        r_cnt_nxt = '0;
        c_cnt_nxt = '0;
        t_cnt_nxt = '0;
        if (in_accept) begin
          unique case (in_if.func)
            FN_LOAD: begin
              plane_we = load_ok;
            end
            FN_ACC: begin
              if (acc_ok) begin
                state_nxt = ST_ACC_DIV;
              end
            end
            FN_DRAIN: begin
              if (drain_ok) begin
                state_nxt = ST_DRN_RD;
              end
            end
            default: begin
              // unused code: dropped
            end
          endcase
        end
      end

      ST_ACC_DIV: begin
        state_nxt = ST_ACC_COL;
      end

      ST_ACC_COL: begin
        state_nxt = ST_ACC_RUN;
      end

      // one tap issued per cycle; write-back trails the read through mac stages a and b
      ST_ACC_RUN: begin
        tap_re            = 1'b1;
        plane_re          = inb;
        issue_ctl.vld     = 1'b1;
        issue_ctl.inb     = inb;
        issue_ctl.acc_vld = acc_vld_r;
        t_cnt_nxt         = t_cnt_r + 1'b1;
        if (c_cnt_r == C_W'(FILTER_COLS - 1)) begin
          c_cnt_nxt = '0;
          r_cnt_nxt = r_cnt_r + 1'b1;
        end else begin
          c_cnt_nxt = c_cnt_r + 1'b1;
        end
        if (t_last) begin
          state_nxt = ST_ACC_FLUSH;
        end
      end

      ST_ACC_FLUSH: begin
        if (!mac_stat.a_vld) begin
          vld_set   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      ST_DRN_RD: begin
        if (out_free) begin
          tap_re    = 1'b1;
          state_nxt = ST_DRN_OUT;
        end
      end

      ST_DRN_OUT: begin
        out_load  = 1'b1;
        t_cnt_nxt = t_cnt_r + 1'b1;
        if (t_last) begin
          vld_clr   = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_DRN_RD;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_valid_nxt = out_load || (out_valid_r && !out_if.ready);
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      r_cnt_r     <= '0;
      c_cnt_r     <= '0;
      t_cnt_r     <= '0;
      pad_r       <= PAD_RESET;
      ch_vld_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      r_cnt_r     <= r_cnt_nxt;
      c_cnt_r     <= c_cnt_nxt;
      t_cnt_r     <= t_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        pad_r <= cfg_wdata;
      end
      if (vld_set) begin
        ch_vld_r[chan_idx] <= 1'b1;
      end
      if (vld_clr) begin
        ch_vld_r[chan_idx] <= 1'b0;
      end
    end
  end

  // payload: request capture, per-item setup, result register
  always_ff @(posedge clk) begin
    if (in_accept) begin
      element_r  <= in_if.element;
      chan_r     <= in_if.out_channel;
      peak_r     <= in_if.peak_index;
      weight_r   <= in_if.weight;
      acc_vld_r  <= ch_vld_r[in_chan_idx];
      tap_base_r <= TA_W'(in_if.out_channel) * TA_W'(TAPS);
    end
    if (state_r == ST_ACC_DIV) begin
      q_r         <= qprod[QPROD_W-1:RECIP_SHIFT];
      elem_base_r <= PA_W'(element_r) * PA_W'(PLANE_SIZE);
    end
    if (state_r == ST_ACC_COL) begin
      col_r <= CL_W'(col_diff);
    end
    if (out_load) begin
      out_value_r <= acc_vld_r ? $signed(tap_rdata) : '0;
      out_tap_r   <= TAP_IDX_W'(t_cnt_r);
      out_chan_r  <= chan_r;
      out_last_r  <= t_last;
    end
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.filter_value    = out_value_r;
  assign out_if.tap_index       = out_tap_r;
  assign out_if.drained_channel = out_chan_r;
  assign out_if.last            = out_last_r;

  // --------------------------------------------------------------------------
  // Memories and update pipeline
  // --------------------------------------------------------------------------
  pwfg_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (PLANE_DEPTH)
  ) u_plane_ram (
    .clk   (clk),
    .we    (plane_we),
    .waddr (plane_waddr),
    .wdata (in_if.pixel_value),
    .re    (plane_re),
    .raddr (plane_raddr),
    .rdata (plane_rdata)
  );

  pwfg_ram #(
    .WIDTH (ACC_W),
    .DEPTH (TAP_DEPTH)
  ) u_tap_ram (
    .clk   (clk),
    .we    (tap_we),
    .waddr (tap_waddr),
    .wdata (tap_wdata),
    .re    (tap_re),
    .raddr (tap_raddr),
    .rdata (tap_rdata)
  );

  pwfg_mac #(
    .AW    (TA_W),
    .SHIFT (SHIFT)
  ) u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ctl  (issue_ctl),
    .in_addr (tap_raddr),
    .weight  (weight_r),
    .sample  (plane_rdata),
    .acc_rd  (tap_rdata),
    .wr_en   (tap_we),
    .wr_addr (tap_waddr),
    .wr_data (tap_wdata),
    .stat    (mac_stat)
  );

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // last flag only on the final tap of a drain
  `PWFG_ASSERT_IMP(a_last_tap, out_valid_r && out_last_r, out_tap_r == TAP_IDX_W'(TAPS - 1))
  // a new request never lands while tap write-backs are still in flight
  `PWFG_ASSERT_IMP(a_accept_drained, in_accept, !mac_stat.a_vld && !mac_stat.b_vld)
  // read of a tap never meets its own pending write-back
  `PWFG_ASSERT_NEVER(a_tap_collide, tap_re && tap_we && (tap_raddr == tap_waddr))

endmodule
